### rtl/core/arm_data_processing_execute_unit_assert.svh
// assertion macros for the execute unit rtl
`ifndef ARM_DATA_PROCESSING_EXECUTE_UNIT_ASSERT_SVH
`define ARM_DATA_PROCESSING_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define AEP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AEP_ASSERT(lbl, clk, rst_n, prop, msg)
`define AEP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/aep_pkg.sv
// types and codes of the data-processing execute unit
`default_nettype none
package aep_pkg;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} aep_opcode_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} aep_shift_t;

	localparam logic [3:0] REG_PC = 4'd15;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] rn_val;
		logic [31:0] rm_val;
		logic [31:0] rs_val;
		logic [3:0]  flags_in;
		logic        mode_has_spsr;
	} aep_in_t;

	typedef struct packed {
		logic [3:0]  dest_index;
		logic [31:0] dest_value;
		logic        dest_write;
		logic        flags_write;
		logic [3:0]  flags_out;
		logic        restore_status;
		logic        unpredictable;
	} aep_out_t;

	// after the shifter
	typedef struct packed {
		aep_opcode_t opc;
		logic        sbit;
		logic [3:0]  rd;
		logic [31:0] rn;
		logic [31:0] op2;
		logic        scarry;
		logic [3:0]  flags;
		logic        has_spsr;
	} aep_s1_t;

	// after the alu
	typedef struct packed {
		logic [3:0]  rd;
		logic [31:0] res;
		logic        c;
		logic        v;
		logic        dest_write;
		logic        flags_write;
		logic        restore;
		logic        unpred;
		logic [3:0]  flags;
	} aep_s2_t;

endpackage
`default_nettype wire

### rtl/core/aep_shift_stage.sv
// decode and barrel shifter, first pipeline stage
`default_nettype none
module aep_shift_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid,
	input  wire aep_pkg::aep_in_t d,
	output logic                valid_s1,
	output aep_pkg::aep_s1_t    q_s1
);
	import aep_pkg::*;

	function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	logic [31:0] w;
	logic [31:0] rm;
	logic        cin;
	logic [4:0]  n;
	logic [7:0]  s;
	logic [4:0]  rot;
	logic [31:0] sign_fill;
	logic [31:0] op2;
	logic        scarry;

	always_comb begin
		w         = d.instr_word;
		rm        = d.rm_val;
		cin       = d.flags_in[1];
		n         = w[11:7];
		s         = d.rs_val[7:0];
		rot       = {w[11:8], 1'b0};
		sign_fill = {32{rm[31]}};
		op2       = rm;
		scarry    = cin;
		if (w[25]) begin
			// rotated 8-bit immediate
			op2    = ror32({24'd0, w[7:0]}, rot);
			scarry = (rot == 5'd0) ? cin : op2[31];
		end else if (!w[4]) begin
			// shift by immediate, zero amount has special meanings
			case (aep_shift_t'(w[6:5]))
				SH_LSL: begin
					if (n != 5'd0) begin
						op2    = rm << n;
						scarry = rm[5'(6'd32 - {1'b0, n})];
					end
				end
				SH_LSR: begin
					if (n == 5'd0) begin
						op2    = 32'd0;
						scarry = rm[31];
					end else begin
						op2    = rm >> n;
						scarry = rm[5'(n - 5'd1)];
					end
				end
				SH_ASR: begin
					if (n == 5'd0) begin
						op2    = sign_fill;
						scarry = rm[31];
					end else begin
						op2    = $unsigned($signed(rm) >>> n);
						scarry = rm[5'(n - 5'd1)];
					end
				end
				SH_ROR: begin
					if (n == 5'd0) begin
						// rrx
						op2    = {cin, rm[31:1]};
						scarry = rm[0];
					end else begin
						op2    = ror32(rm, n);
						scarry = rm[5'(n - 5'd1)];
					end
				end
				default: begin
					op2    = rm;
					scarry = cin;
				end
			endcase
		end else if (s != 8'd0) begin
			// shift by the low byte of rs
			case (aep_shift_t'(w[6:5]))
				SH_LSL: begin
					if (s < 8'd32) begin
						op2    = rm << s[4:0];
						scarry = rm[5'(6'd32 - {1'b0, s[4:0]})];
					end else begin
						op2    = 32'd0;
						scarry = (s == 8'd32) ? rm[0] : 1'b0;
					end
				end
				SH_LSR: begin
					if (s < 8'd32) begin
						op2    = rm >> s[4:0];
						scarry = rm[5'(s[4:0] - 5'd1)];
					end else begin
						op2    = 32'd0;
						scarry = (s == 8'd32) ? rm[31] : 1'b0;
					end
				end
				SH_ASR: begin
					if (s < 8'd32) begin
						op2    = $unsigned($signed(rm) >>> s[4:0]);
						scarry = rm[5'(s[4:0] - 5'd1)];
					end else begin
						op2    = sign_fill;
						scarry = rm[31];
					end
				end
				SH_ROR: begin
					if (s[4:0] == 5'd0) begin
						op2    = rm;
						scarry = rm[31];
					end else begin
						op2    = ror32(rm, s[4:0]);
						scarry = rm[5'(s[4:0] - 5'd1)];
					end
				end
				default: begin
					op2    = rm;
					scarry = cin;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid) begin
			q_s1.opc      <= aep_opcode_t'(d.instr_word[24:21]);
			q_s1.sbit     <= d.instr_word[20];
			q_s1.rd       <= d.instr_word[15:12];
			q_s1.rn       <= d.rn_val;
			q_s1.op2      <= op2;
			q_s1.scarry   <= scarry;
			q_s1.flags    <= d.flags_in;
			q_s1.has_spsr <= d.mode_has_spsr;
		end
	end

endmodule
`default_nettype wire

### rtl/core/aep_alu_stage.sv
// alu with 33-bit adder and write control, second pipeline stage
`default_nettype none
module aep_alu_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid,
	input  wire aep_pkg::aep_s1_t d,
	output logic                valid_s2,
	output aep_pkg::aep_s2_t    q_s2
);
	import aep_pkg::*;

	logic [31:0] x;
	logic [31:0] y;
	logic        ci;
	logic        arith;
	logic [31:0] logic_res;
	logic [32:0] sum;
	logic [31:0] res;
	logic        c;
	logic        v;
	logic        compare;
	logic        rd_pc;

	always_comb begin
		x         = d.rn;
		y         = d.op2;
		ci        = 1'b0;
		arith     = 1'b0;
		logic_res = 32'd0;
		case (d.opc)
			OP_AND, OP_TST: logic_res = d.rn & d.op2;
			OP_EOR, OP_TEQ: logic_res = d.rn ^ d.op2;
			OP_SUB, OP_CMP: begin
				y     = ~d.op2;
				ci    = 1'b1;
				arith = 1'b1;
			end
			OP_RSB: begin
				x     = d.op2;
				y     = ~d.rn;
				ci    = 1'b1;
				arith = 1'b1;
			end
			OP_ADD, OP_CMN: arith = 1'b1;
			OP_ADC: begin
				ci    = d.flags[1];
				arith = 1'b1;
			end
			OP_SBC: begin
				y     = ~d.op2;
				ci    = d.flags[1];
				arith = 1'b1;
			end
			OP_RSC: begin
				x     = d.op2;
				y     = ~d.rn;
				ci    = d.flags[1];
				arith = 1'b1;
			end
			OP_ORR: logic_res = d.rn | d.op2;
			OP_MOV: logic_res = d.op2;
			OP_BIC: logic_res = d.rn & ~d.op2;
			OP_MVN: logic_res = ~d.op2;
			default: logic_res = ~d.op2;
		endcase
		sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
		if (arith) begin
			res = sum[31:0];
			c   = sum[32];
			v   = (x[31] ^ sum[31]) & (y[31] ^ sum[31]);
		end else begin
			// logical ops: shifter carry, v untouched
			res = logic_res;
			c   = d.scarry;
			v   = d.flags[0];
		end
		compare = (d.opc == OP_TST) || (d.opc == OP_TEQ) ||
			(d.opc == OP_CMP) || (d.opc == OP_CMN);
		rd_pc   = (d.rd == REG_PC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid) begin
			q_s2.rd          <= d.rd;
			q_s2.res         <= res;
			q_s2.c           <= c;
			q_s2.v           <= v;
			q_s2.dest_write  <= !compare;
			q_s2.flags_write <= compare || (d.sbit && !rd_pc);
			q_s2.restore     <= !compare && d.sbit && rd_pc && d.has_spsr;
			q_s2.unpred      <= !compare && d.sbit && rd_pc && !d.has_spsr;
			q_s2.flags       <= d.flags;
		end
	end

endmodule
`default_nettype wire

### rtl/core/aep_flag_stage.sv
// nzcv build and result register, third pipeline stage
`default_nettype none
module aep_flag_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid,
	input  wire aep_pkg::aep_s2_t d,
	output logic                valid_s3,
	output aep_pkg::aep_out_t   q_s3
);
	import aep_pkg::*;

	logic [3:0] nzcv;

	always_comb begin
		nzcv = {d.res[31], (d.res == 32'd0), d.c, d.v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid) begin
			q_s3.dest_index     <= d.rd;
			q_s3.dest_value     <= d.res;
			q_s3.dest_write     <= d.dest_write;
			q_s3.flags_write    <= d.flags_write;
			q_s3.flags_out      <= d.flags_write ? nzcv : d.flags;
			q_s3.restore_status <= d.restore;
			q_s3.unpredictable  <= d.unpred;
		end
	end

endmodule
`default_nettype wire

### rtl/core/arm_data_processing_execute_unit.sv
// top level of the armv5 data-processing execute unit
//
//  channel  | valid        | stall        | payload         | dir
//  ---------+--------------+--------------+-----------------+-----
//  instr    | instr_valid  | instr_stall  | instr  aep_in_t  | in
//  result   | result_valid | result_stall | result aep_out_t | out
//
// one item accepted per cycle while instr_stall is low, each passing the shift, alu and flags stages in order
// the three stage registers carry a valid bit each, cleared by arst_n
// a stage loads when it is empty or the stage after it moves, so bubbles close up
// instr_stall rises only when all three stages hold items and result_stall is high
// the result register is the output register, stalled items sit there unchanged
`default_nettype none
`include "arm_data_processing_execute_unit_assert.svh"
module arm_data_processing_execute_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          instr_valid,
	output logic               instr_stall,
	input  wire aep_pkg::aep_in_t instr,
	output logic               result_valid,
	input  wire logic          result_stall,
	output aep_pkg::aep_out_t  result
);
	import aep_pkg::*;

	// per-stage valid and load enables
	logic     valid_s1;
	logic     valid_s2;
	logic     valid_s3;
	logic     en1;
	logic     en2;
	logic     en3;
	aep_s1_t  shift_s1;
	aep_s2_t  alu_s2;

	// enable chain from the output back to the input
	always_comb begin
		en3         = !valid_s3 || !result_stall;
		en2         = !valid_s2 || en3;
		en1         = !valid_s1 || en2;
		instr_stall = !en1;
	end

	// stage 1: decode and barrel shifter
	aep_shift_stage u_shift (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.valid    (instr_valid),
		.d        (instr),
		.valid_s1 (valid_s1),
		.q_s1     (shift_s1)
	);

	// stage 2: logic ops and 33-bit adder, write control
	aep_alu_stage u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid    (valid_s1),
		.d        (shift_s1),
		.valid_s2 (valid_s2),
		.q_s2     (alu_s2)
	);

	// stage 3: n and z from the result, flag select, output register
	aep_flag_stage u_flag (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid    (valid_s2),
		.d        (alu_s2),
		.valid_s3 (valid_s3),
		.q_s3     (result)
	);

	assign result_valid = valid_s3;

	// a full pipe with a stalled output must push back
	`AEP_ASSERT(a_full_stall, clk, arst_n,
		(valid_s1 && valid_s2 && valid_s3 && result_stall) |-> instr_stall,
		"full pipe did not stall input")
	// an empty first stage always takes an item
	`AEP_ASSERT(a_empty_accepts, clk, arst_n, !valid_s1 |-> !instr_stall,
		"input stalled with empty first stage")
	// compare ops never write rd but always write flags
	`AEP_ASSERT(a_compare_flags, clk, arst_n,
		(result_valid && !result.dest_write) |-> result.flags_write,
		"compare without flag write")
	// spsr restore and unpredictable only for rd equal to pc and never with a flag write
	`AEP_ASSERT(a_restore_excl, clk, arst_n,
		(result_valid && (result.restore_status || result.unpredictable)) |->
		(!result.flags_write && !(result.restore_status && result.unpredictable) &&
		result.dest_index == REG_PC),
		"bad restore or unpredictable mark")

endmodule
`default_nettype wire
